/* rtl/sexpr_lexer_unit_assert.svh */
// ----------------------------------------------------------------------------
// sexpr_lexer_unit assertion macros
// Shared property forms for the lexer checks: same-cycle and next-cycle
// implication, clocked on clk and quiet during reset.
// ----------------------------------------------------------------------------
`ifndef SEXPR_LEXER_UNIT_ASSERT_SVH
`define SEXPR_LEXER_UNIT_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define SLU_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("sexpr_lexer_unit: same-cycle check failed");

// antecedent implies consequent in the next cycle
`define SLU_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("sexpr_lexer_unit: next-cycle check failed");

`endif

/* rtl/sexpr_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sexpr_pkg
// Beat types, role codes and character constants of the s-expression lexer.
// ----------------------------------------------------------------------------
package sexpr_pkg;

  typedef struct packed {
    logic [7:0] byte_in;
    logic       end_of_text;
  } item_t;

  typedef struct packed {
    logic [7:0] byte_out;
    logic [2:0] role;
    logic       token_start;
    logic       prev_token_ended;
    logic       escaped_quote;
    logic       string_unclosed;
  } result_t;

  localparam logic [2:0] ROLE_SPACE   = 3'd0;
  localparam logic [2:0] ROLE_COMMENT = 3'd1;
  localparam logic [2:0] ROLE_OPEN    = 3'd2;
  localparam logic [2:0] ROLE_CLOSE   = 3'd3;
  localparam logic [2:0] ROLE_QUOTE   = 3'd4;
  localparam logic [2:0] ROLE_STRING  = 3'd5;
  localparam logic [2:0] ROLE_SYMBOL  = 3'd6;
  localparam logic [2:0] ROLE_END     = 3'd7;

  localparam logic [7:0] CH_OPEN   = 8'h28;
  localparam logic [7:0] CH_CLOSE  = 8'h29;
  localparam logic [7:0] CH_QUOTE  = 8'h27;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_BSLASH = 8'h5C;

endpackage

/* rtl/sexpr_lexer_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sexpr_lexer_unit
// Streaming s-expression tokenizer: labels each byte with its lexical role
// and token boundary marks; an end beat closes any open token.
// ----------------------------------------------------------------------------
//   channel   payload    handshake                  beat
//   item      item_t     item_valid / item_stall    one source byte or end mark
//   result    result_t   result_valid / result_stall one labeled byte
//
// One beat in, one beat out; a beat can enter every cycle while item_stall is low.
// Classification sits between the item port and the result register,
// with the mode register deciding each byte.
// A one-entry skid register takes a beat while the result is stalled;
// item_stall rises only when that skid entry is full.
// Reset clears mode, escape flag and both valid bits.
// ----------------------------------------------------------------------------
module sexpr_lexer_unit
  import sexpr_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    item_valid,
  output logic    item_stall,
  input  item_t   item,
  output logic    result_valid,
  input  logic    result_stall,
  output result_t result
);

  typedef enum logic [1:0] {
    MODE_IDLE,
    MODE_COMMENT,
    MODE_STRING,
    MODE_SYMBOL
  } mode_t;

  mode_t   mode, mode_next;
  logic    after_bs, after_bs_next;
  result_t res;
  result_t skid;
  logic    skid_valid;

  // classification of a byte when no token is open
  logic [2:0] idle_role;
  logic       idle_start;
  mode_t      idle_mode;
  logic       is_space;
  logic       is_term;
  logic       item_fire;
  logic       out_free;

  assign item_stall = skid_valid;
  assign item_fire  = item_valid && !skid_valid;
  assign out_free   = !result_valid || !result_stall;

  always_comb begin
    is_space = item.byte_in inside {8'h20, [8'h09:8'h0D]};
    is_term  = is_space || item.byte_in == CH_OPEN || item.byte_in == CH_CLOSE;
  end

  always_comb begin
    idle_role  = ROLE_SYMBOL;
    idle_start = 1'b1;
    idle_mode  = MODE_IDLE;
    if (is_space) begin
      idle_role  = ROLE_SPACE;
      idle_start = 1'b0;
    end else begin
      case (item.byte_in)
        CH_SEMI: begin
          idle_role  = ROLE_COMMENT;
          idle_start = 1'b0;
          idle_mode  = MODE_COMMENT;
        end
        CH_OPEN:   idle_role = ROLE_OPEN;
        CH_CLOSE:  idle_role = ROLE_CLOSE;
        CH_QUOTE:  idle_role = ROLE_QUOTE;
        CH_DQUOTE: begin
          idle_role = ROLE_STRING;
          idle_mode = MODE_STRING;
        end
        default: begin
          idle_role = ROLE_SYMBOL;
          idle_mode = MODE_SYMBOL;
        end
      endcase
    end
  end

  always_comb begin
    mode_next     = mode;
    after_bs_next = after_bs;
    res           = '0;
    res.byte_out  = item.byte_in;
    res.role      = ROLE_SPACE;
    if (item.end_of_text) begin
      res.byte_out         = 8'h00;
      res.role             = ROLE_END;
      res.prev_token_ended = (mode == MODE_SYMBOL);
      res.string_unclosed  = (mode == MODE_STRING);
      mode_next            = MODE_IDLE;
      after_bs_next        = 1'b0;
    end else begin
      case (mode)
        MODE_COMMENT: begin
          res.role = ROLE_COMMENT;
          if (item.byte_in == CH_NL) begin
            mode_next = MODE_IDLE;
          end
        end
        MODE_STRING: begin
          res.role = ROLE_STRING;
          if (item.byte_in == CH_DQUOTE) begin
            // a quote right after a backslash stays inside the string
            res.escaped_quote = after_bs;
            if (!after_bs) begin
              mode_next = MODE_IDLE;
            end
            after_bs_next = 1'b0;
          end else begin
            after_bs_next = (item.byte_in == CH_BSLASH);
          end
        end
        MODE_SYMBOL: begin
          if (is_term) begin
            res.prev_token_ended = 1'b1;
            res.role             = idle_role;
            res.token_start      = idle_start;
            mode_next            = idle_mode;
          end else begin
            res.role = ROLE_SYMBOL;
          end
        end
        default: begin
          res.role        = idle_role;
          res.token_start = idle_start;
          mode_next       = idle_mode;
          if (idle_mode == MODE_STRING) begin
            after_bs_next = 1'b0;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode         <= MODE_IDLE;
      after_bs     <= 1'b0;
      result_valid <= 1'b0;
      skid_valid   <= 1'b0;
    end else begin
      if (item_fire) begin
        mode     <= mode_next;
        after_bs <= after_bs_next;
      end
      if (out_free) begin
        if (skid_valid) begin
          result       <= skid;
          result_valid <= 1'b1;
          skid_valid   <= 1'b0;
        end else if (item_fire) begin
          result       <= res;
          result_valid <= 1'b1;
        end else begin
          result_valid <= 1'b0;
        end
      end else if (item_fire) begin
        skid       <= res;
        skid_valid <= 1'b1;
      end
    end
  end

endmodule

/* rtl/sexpr_chk.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sexpr_chk
// Port-level checks of the lexer result stream, bound to sexpr_lexer_unit.
// ----------------------------------------------------------------------------
`include "sexpr_lexer_unit_assert.svh"

module sexpr_chk
  import sexpr_pkg::*;
(
  input logic    clk,
  input logic    rst,
  input logic    item_valid,
  input logic    item_stall,
  input item_t   item,
  input logic    result_valid,
  input logic    result_stall,
  input result_t result
);

  logic rv;
  assign rv = result_valid;

  // a stalled result beat holds
  `SLU_ASSERT_NEXT(a_result_hold, rv && result_stall, rv && $stable(result))

  // end beats carry no byte and start nothing
  `SLU_ASSERT_NOW(a_end_clean, rv && result.role == ROLE_END,
                  result.byte_out == 8'h00 && !result.token_start && !result.escaped_quote)

  // only the end beat reports an open string
  `SLU_ASSERT_NOW(a_unclosed_end, rv && result.string_unclosed, result.role == ROLE_END)

  // an escaped quote is a double quote inside a string
  `SLU_ASSERT_NOW(a_esc_quote, rv && result.escaped_quote,
                  result.byte_out == CH_DQUOTE && result.role == ROLE_STRING)

  // space, comment and end beats never open a token
  `SLU_ASSERT_NOW(a_start_role, rv && result.token_start,
                  result.role != ROLE_SPACE && result.role != ROLE_COMMENT &&
                  result.role != ROLE_END)

  logic unused_in;
  assign unused_in = item_valid ^ item_stall ^ (^item);

endmodule

bind sexpr_lexer_unit sexpr_chk u_sexpr_chk (
  .clk          (clk),
  .rst          (rst),
  .item_valid   (item_valid),
  .item_stall   (item_stall),
  .item         (item),
  .result_valid (result_valid),
  .result_stall (result_stall),
  .result       (result)
);

/* test/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench for sexpr_lexer_unit
// Streams source text into the lexer and checks every labeled beat against a
// behavioral lexer kept inside the bench. Directed text covers each role,
// comment and string edge cases, and end beats in idle, symbol and comment
// mode. Random text follows: mostly well-formed tokens with random content,
// plus raw noise. The item channel idles and the result channel stalls at random.
// ----------------------------------------------------------------------------
module testbench;
  import sexpr_pkg::*;

  typedef enum logic [1:0] {
    LX_IDLE    = 2'd0,
    LX_COMMENT = 2'd1,
    LX_STRING  = 2'd2,
    LX_SYMBOL  = 2'd3
  } lex_mode_t;

  localparam int RANDOM_BYTES = 1450;
  localparam int DRAIN_CYCLES = 8;

  logic    clk = 1'b0;
  logic    rst = 1'b1;
  logic    item_valid = 1'b0;
  logic    item_stall;
  item_t   item_beat = '0;
  logic    result_valid;
  logic    result_stall = 1'b0;
  result_t result_beat;

  sexpr_lexer_unit uut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item_beat),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result_beat)
  );

  // source text waiting to go out; a set hold bit makes that beat wait until
  // every labeled byte in flight has come back
  item_t     source_bytes[$];
  bit        source_hold[$];
  result_t   labeled_bytes_due[$];
  bit        hold_next = 1'b0;
  int        mismatch_count = 0;

  lex_mode_t lex_mode = LX_IDLE;
  logic      lex_escape_pending = 1'b0;

  int        send_gap = 0;
  int        send_calm = 0;
  int        stall_left = 0;
  int        stall_calm = 0;
  result_t   want;

  initial begin
    forever #6 clk = ~clk;
  end

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
  end

  initial begin
    #10ms;
    $display("testbench: errors");
    $finish;
  end

  // ---------------------------------------------------------------- lexer
  function automatic bit is_blank(input logic [7:0] c);
    return c == 8'h20 || (c >= 8'h09 && c <= 8'h0D);
  endfunction

  // byte seen while no token is open
  function automatic void open_token(input logic [7:0] c, inout result_t r);
    r.token_start = 1'b1;
    if (is_blank(c)) begin
      r.role = ROLE_SPACE;
      r.token_start = 1'b0;
    end else if (c == CH_SEMI) begin
      r.role = ROLE_COMMENT;
      r.token_start = 1'b0;
      lex_mode = LX_COMMENT;
    end else if (c == CH_OPEN) begin
      r.role = ROLE_OPEN;
    end else if (c == CH_CLOSE) begin
      r.role = ROLE_CLOSE;
    end else if (c == CH_QUOTE) begin
      r.role = ROLE_QUOTE;
    end else if (c == CH_DQUOTE) begin
      r.role = ROLE_STRING;
      lex_mode = LX_STRING;
      lex_escape_pending = 1'b0;
    end else begin
      r.role = ROLE_SYMBOL;
      lex_mode = LX_SYMBOL;
    end
  endfunction

  function automatic result_t label_byte(input item_t it);
    result_t    r;
    logic [7:0] c;
    r = '0;
    c = it.byte_in;
    r.byte_out = c;
    if (it.end_of_text) begin
      r.byte_out = 8'h00;
      r.role = ROLE_END;
      r.prev_token_ended = (lex_mode == LX_SYMBOL);
      r.string_unclosed = (lex_mode == LX_STRING);
      lex_mode = LX_IDLE;
      lex_escape_pending = 1'b0;
    end else begin
      case (lex_mode)
        LX_COMMENT: begin
          r.role = ROLE_COMMENT;
          if (c == CH_NL) lex_mode = LX_IDLE;
        end
        LX_STRING: begin
          r.role = ROLE_STRING;
          if (c == CH_DQUOTE) begin
            if (lex_escape_pending) r.escaped_quote = 1'b1;
            else lex_mode = LX_IDLE;
            lex_escape_pending = 1'b0;
          end else begin
            lex_escape_pending = (c == CH_BSLASH);
          end
        end
        LX_SYMBOL: begin
          if (is_blank(c) || c == CH_OPEN || c == CH_CLOSE) begin
            r.prev_token_ended = 1'b1;
            lex_mode = LX_IDLE;
            open_token(c, r);
          end else begin
            r.role = ROLE_SYMBOL;
          end
        end
        default: open_token(c, r);
      endcase
    end
    return r;
  endfunction

  // ------------------------------------------------------------ stimulus
  task automatic push_char(input logic [7:0] c);
    item_t it;
    it.byte_in = c;
    it.end_of_text = 1'b0;
    source_bytes.push_back(it);
    source_hold.push_back(hold_next);
    hold_next = 1'b0;
  endtask

  task automatic push_end(input logic [7:0] c);
    item_t it;
    it.byte_in = c;
    it.end_of_text = 1'b1;
    source_bytes.push_back(it);
    source_hold.push_back(hold_next);
    hold_next = 1'b0;
  endtask

  function automatic logic [7:0] blank_char();
    int k;
    k = $urandom_range(0, 5);
    return (k == 5) ? 8'h20 : 8'(8'h09 + k);
  endfunction

  function automatic logic [7:0] symbol_char();
    logic [7:0] c;
    case ($urandom_range(0, 9))
      0: c = CH_QUOTE;
      1: c = CH_DQUOTE;
      2: c = CH_SEMI;
      3, 4, 5: c = 8'($urandom_range(8'h61, 8'h7A));
      default: begin
        do c = 8'($urandom_range(0, 255));
        while (is_blank(c) || c == CH_OPEN || c == CH_CLOSE);
      end
    endcase
    return c;
  endfunction

  task automatic add_token();
    int n;
    int r;
    r = $urandom_range(0, 99);
    if (r < 25) begin
      n = $urandom_range(1, 6);
      repeat (n) push_char(symbol_char());
      case ($urandom_range(0, 3))
        0: push_char(CH_OPEN);
        1: push_char(CH_CLOSE);
        default: push_char(blank_char());
      endcase
    end else if (r < 37) begin
      repeat ($urandom_range(1, 3)) push_char(blank_char());
    end else if (r < 47) begin
      push_char(CH_OPEN);
    end else if (r < 57) begin
      push_char(CH_CLOSE);
    end else if (r < 62) begin
      push_char(CH_QUOTE);
    end else if (r < 77) begin
      push_char(CH_DQUOTE);
      n = $urandom_range(0, 8);
      repeat (n) begin
        case ($urandom_range(0, 9))
          0, 1: push_char(CH_BSLASH);
          2: begin
            push_char(CH_BSLASH);
            push_char(CH_DQUOTE);
          end
          3: push_char(CH_NL);
          4, 5: push_char(8'($urandom_range(0, 255)));
          default: push_char(8'($urandom_range(8'h20, 8'h7E)));
        endcase
      end
      if ($urandom_range(0, 9) != 0) push_char(CH_DQUOTE);
    end else if (r < 87) begin
      push_char(CH_SEMI);
      n = $urandom_range(0, 8);
      repeat (n) begin
        logic [7:0] c;
        do c = 8'($urandom_range(0, 255));
        while (c == CH_NL);
        push_char(c);
      end
      if ($urandom_range(0, 9) != 0) push_char(CH_NL);
    end else if (r < 90) begin
      push_end(8'($urandom_range(0, 255)));
    end else begin
      repeat ($urandom_range(1, 4)) push_char(8'($urandom_range(0, 255)));
    end
  endtask

  initial begin
    int cutoff;
    // directed text
    push_char("x");
    push_char(CH_QUOTE);
    push_char(CH_DQUOTE);
    push_char(CH_SEMI);
    push_char(CH_OPEN);      // ends the symbol
    push_char(8'hFF);
    push_char(8'h00);        // zero byte is plain symbol content
    push_char(8'h09);        // tab ends the symbol
    push_char(CH_CLOSE);
    push_char(CH_QUOTE);
    push_char(CH_SEMI);
    push_char(8'h80);
    push_char(CH_NL);        // closes the comment
    push_char(CH_DQUOTE);
    push_char(CH_BSLASH);
    push_char(CH_DQUOTE);    // escaped, stays in the string
    push_char(CH_BSLASH);
    push_char(CH_BSLASH);
    push_char(CH_DQUOTE);    // second backslash keeps the escape: stays in the string
    push_char(CH_DQUOTE);
    push_end(8'hFF);         // string already closed: idle end
    push_char("z");
    push_end(8'h00);         // symbol left open
    push_char(CH_SEMI);
    push_end(8'h5A);         // comment left open
    push_end(8'hA5);         // idle end

    // random text; the first random beat waits for the directed part to drain
    hold_next = 1'b1;
    cutoff = source_bytes.size() + RANDOM_BYTES;
    while (source_bytes.size() < cutoff) begin
      if ($urandom_range(0, 149) == 0) hold_next = 1'b1;
      add_token();
    end
    push_end(8'($urandom_range(0, 255)));

    @(negedge clk);
    while (rst) @(negedge clk);
    while (source_bytes.size() != 0 || item_valid || labeled_bytes_due.size() != 0)
      @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (labeled_bytes_due.size() != 0)
      $display("%0t: %0d labeled bytes never arrived", $time, labeled_bytes_due.size());
    if (mismatch_count == 0 && labeled_bytes_due.size() == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

  // mostly no pause or short ones, a few long ones, and now and then a stretch of none
  function automatic int pick_pause(inout int calm);
    int r;
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 199) == 0) calm = $urandom_range(40, 160);
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(6, 30);
  endfunction

  // --------------------------------------------------------------- driver
  always @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else begin
      if (item_valid && !item_stall) begin
        labeled_bytes_due.push_back(label_byte(item_beat));
        send_gap = pick_pause(send_calm);
      end
      if (item_valid && item_stall) begin
        // stalled beat stays as it is
      end else if (send_gap > 0) begin
        send_gap--;
        item_valid <= 1'b0;
      end else if (source_bytes.size() != 0 &&
                   !(source_hold[0] && labeled_bytes_due.size() != 0)) begin
        item_beat <= source_bytes.pop_front();
        void'(source_hold.pop_front());
        item_valid <= 1'b1;
      end else begin
        item_valid <= 1'b0;
      end
    end
  end

  // -------------------------------------------------------------- monitor
  task automatic check_field(input string name, input int unsigned exp_v,
                             input int unsigned got_v);
    if (exp_v != got_v) begin
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, exp_v, got_v);
      mismatch_count++;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      result_stall <= 1'b0;
    end else begin
      if (result_valid && !result_stall) begin
        if (labeled_bytes_due.size() == 0) begin
          $display("%0t: beat with nothing expected, expected none, got %h",
                   $time, result_beat);
          mismatch_count++;
        end else begin
          want = labeled_bytes_due.pop_front();
          check_field("byte_out", 32'(want.byte_out), 32'(result_beat.byte_out));
          check_field("role", 32'(want.role), 32'(result_beat.role));
          check_field("token_start", 32'(want.token_start),
                      32'(result_beat.token_start));
          check_field("prev_token_ended", 32'(want.prev_token_ended),
                      32'(result_beat.prev_token_ended));
          check_field("escaped_quote", 32'(want.escaped_quote),
                      32'(result_beat.escaped_quote));
          check_field("string_unclosed", 32'(want.string_unclosed),
                      32'(result_beat.string_unclosed));
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        result_stall <= 1'b1;
      end else begin
        stall_left = pick_pause(stall_calm);
        if (stall_left > 0) begin
          stall_left--;
          result_stall <= 1'b1;
        end else begin
          result_stall <= 1'b0;
        end
      end
    end
  end

endmodule

/* sim.f */
+incdir+rtl
rtl/sexpr_pkg.sv
rtl/sexpr_lexer_unit.sv
rtl/sexpr_chk.sv
test/testbench.sv
